FILE: rtl/mtp_pkg.sv
`timescale 1ns / 1ps
package mtp_pkg;

  localparam int AngPi       = 12868;
  localparam int AngTwoPi    = 25736;
  localparam int CordicPi    = 205887;
  localparam int CordicSteps = 17;
  localparam int SqrtSteps   = 32;

  localparam logic [2:0] CfgGoalX     = 3'd0;
  localparam logic [2:0] CfgGoalY     = 3'd1;
  localparam logic [2:0] CfgGoalHead  = 3'd2;
  localparam logic [2:0] CfgGainDist  = 3'd3;
  localparam logic [2:0] CfgGainBear  = 3'd4;
  localparam logic [2:0] CfgGainFinal = 3'd5;
  localparam logic [2:0] CfgStopDist  = 3'd6;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIFF,
    ST_SQX,
    ST_SQY,
    ST_START,
    ST_RUN,
    ST_ALPHA,
    ST_BETA,
    ST_MULA,
    ST_MULB,
    ST_FIN
  } mtp_state_e;

  typedef struct packed {
    logic load;
    logic diff;
    logic sq_x;
    logic sq_y;
    logic start;
    logic run;
    logic alpha;
    logic beta;
    logic mul_a;
    logic mul_b;
    logic fin;
  } mtp_cmd_t;

  typedef struct packed {
    logic run_done;
    logic out_busy;
  } mtp_status_t;

  // atan(2^-i) in rad*65536
  function automatic logic signed [19:0] atan_entry(input logic [4:0] i);
    logic signed [19:0] r;
    r = '0;
    case (i)
      5'd0:  r = 20'sd51472;
      5'd1:  r = 20'sd30386;
      5'd2:  r = 20'sd16055;
      5'd3:  r = 20'sd8150;
      5'd4:  r = 20'sd4091;
      5'd5:  r = 20'sd2047;
      5'd6:  r = 20'sd1024;
      5'd7:  r = 20'sd512;
      5'd8:  r = 20'sd256;
      5'd9:  r = 20'sd128;
      5'd10: r = 20'sd64;
      5'd11: r = 20'sd32;
      5'd12: r = 20'sd16;
      5'd13: r = 20'sd8;
      5'd14: r = 20'sd4;
      5'd15: r = 20'sd2;
      5'd16: r = 20'sd1;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

FILE: rtl/mtp_in_if.sv
`timescale 1ns / 1ps
interface mtp_in_if;
  logic               valid;
  logic               ready;
  logic               load_start;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic signed [14:0] heading_in;

  modport source(output valid, load_start, pos_x, pos_y, heading_in, input ready);
  modport sink(input valid, load_start, pos_x, pos_y, heading_in, output ready);
endinterface

FILE: rtl/mtp_out_if.sv
`timescale 1ns / 1ps
interface mtp_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] speed;
  logic signed [31:0] turn_rate;
  logic        [31:0] distance;
  logic signed [15:0] bearing_error;
  logic signed [16:0] final_angle_error;
  logic               arrived;

  modport source(output valid, speed, turn_rate, distance, bearing_error,
                 final_angle_error, arrived, input ready);
  modport sink(input valid, speed, turn_rate, distance, bearing_error,
               final_angle_error, arrived, output ready);
endinterface

FILE: rtl/mtp_cfg_if.sv
`timescale 1ns / 1ps
interface mtp_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [31:0] data;

  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

FILE: rtl/mtp_ctrl.sv
`timescale 1ns / 1ps
module mtp_ctrl
  import mtp_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  mtp_status_t status_i,
  output mtp_cmd_t    cmd_o
);

  mtp_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:  if (in_valid_i) state_d = ST_DIFF;
      ST_DIFF:  state_d = ST_SQX;
      ST_SQX:   state_d = ST_SQY;
      ST_SQY:   state_d = ST_START;
      ST_START: state_d = ST_RUN;
      ST_RUN:   if (status_i.run_done) state_d = ST_ALPHA;
      ST_ALPHA: state_d = ST_BETA;
      ST_BETA:  state_d = ST_MULA;
      ST_MULA:  state_d = ST_MULB;
      ST_MULB:  state_d = ST_FIN;
      ST_FIN:   if (!status_i.out_busy) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      ST_DIFF:  cmd_o.diff  = 1'b1;
      ST_SQX:   cmd_o.sq_x  = 1'b1;
      ST_SQY:   cmd_o.sq_y  = 1'b1;
      ST_START: cmd_o.start = 1'b1;
      ST_RUN:   cmd_o.run   = 1'b1;
      ST_ALPHA: cmd_o.alpha = 1'b1;
      ST_BETA:  cmd_o.beta  = 1'b1;
      ST_MULA:  cmd_o.mul_a = 1'b1;
      ST_MULB:  cmd_o.mul_b = 1'b1;
      ST_FIN:   cmd_o.fin   = !status_i.out_busy;
      default:  cmd_o = '0;
    endcase
  end

endmodule

FILE: rtl/mtp_datapath.sv
`timescale 1ns / 1ps
module mtp_datapath
  import mtp_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  mtp_cmd_t           cmd_i,
  output mtp_status_t        status_o,
  input  logic               load_start_i,
  input  logic signed [31:0] pos_x_i,
  input  logic signed [31:0] pos_y_i,
  input  logic signed [14:0] heading_in_i,
  input  logic               cfg_valid_i,
  input  logic [2:0]         cfg_index_i,
  input  logic [31:0]        cfg_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [31:0] speed_o,
  output logic signed [31:0] turn_rate_o,
  output logic        [31:0] distance_o,
  output logic signed [15:0] bearing_error_o,
  output logic signed [16:0] final_angle_error_o,
  output logic               arrived_o
);

  localparam logic signed [43:0] NormLimit = 44'sh40_0000_0000;
  localparam logic [4:0]         CordicEnd = 5'(CordicSteps);

  // configuration
  logic signed [31:0] goal_x_q, goal_y_q;
  logic signed [14:0] goal_head_q;
  logic signed [15:0] gain_dist_q, gain_bear_q, gain_final_q;
  logic        [31:0] stop_dist_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      goal_x_q     <= '0;
      goal_y_q     <= '0;
      goal_head_q  <= '0;
      gain_dist_q  <= 16'sd2304;
      gain_bear_q  <= 16'sd3840;
      gain_final_q <= -16'sd768;
      stop_dist_q  <= 32'd66;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CfgGoalX:     goal_x_q     <= cfg_data_i;
        CfgGoalY:     goal_y_q     <= cfg_data_i;
        CfgGoalHead:  goal_head_q  <= cfg_data_i[14:0];
        CfgGainDist:  gain_dist_q  <= cfg_data_i[15:0];
        CfgGainBear:  gain_bear_q  <= cfg_data_i[15:0];
        CfgGainFinal: gain_final_q <= cfg_data_i[15:0];
        CfgStopDist:  stop_dist_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // pose
  logic signed [31:0] pose_x_q, pose_y_q;
  logic signed [14:0] heading_q;
  logic signed [32:0] sum_x, sum_y;

  assign sum_x = {pose_x_q[31], pose_x_q} + {pos_x_i[31], pos_x_i};
  assign sum_y = {pose_y_q[31], pose_y_q} + {pos_y_i[31], pos_y_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pose_x_q  <= '0;
      pose_y_q  <= '0;
      heading_q <= '0;
    end else if (cmd_i.load) begin
      heading_q <= heading_in_i;
      if (load_start_i) begin
        pose_x_q <= pos_x_i;
        pose_y_q <= pos_y_i;
      end else begin
        if (sum_x[32] != sum_x[31]) begin
          pose_x_q <= sum_x[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        end else begin
          pose_x_q <= sum_x[31:0];
        end
        if (sum_y[32] != sum_y[31]) begin
          pose_y_q <= sum_y[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        end else begin
          pose_y_q <= sum_y[31:0];
        end
      end
    end
  end

  // vector to goal and squares
  logic signed [32:0] dx_q, dy_q, ax_full, ay_full;
  logic        [31:0] mul_op;
  logic        [63:0] sq_prod, sqx_q, sqy_q;

  assign ax_full = dx_q[32] ? -dx_q : dx_q;
  assign ay_full = dy_q[32] ? -dy_q : dy_q;
  assign mul_op  = cmd_i.sq_x ? ax_full[31:0] : ay_full[31:0];
  assign sq_prod = mul_op * mul_op;

  always_ff @(posedge clk_i) begin
    if (cmd_i.diff) begin
      dx_q <= {goal_x_q[31], goal_x_q} - {pose_x_q[31], pose_x_q};
      dy_q <= {goal_y_q[31], goal_y_q} - {pose_y_q[31], pose_y_q};
    end
    if (cmd_i.sq_x) sqx_q <= sq_prod;
    if (cmd_i.sq_y) sqy_q <= sq_prod;
  end

  // square root, one result bit a cycle
  logic [64:0] sq_sum;
  logic [63:0] rad_q;
  logic [33:0] rem_q, rem_n, trial;
  logic [31:0] root_q;
  logic [5:0]  sq_cnt_q;
  logic        ovf_q;

  assign sq_sum = {1'b0, sqx_q} + {1'b0, sqy_q};
  assign rem_n  = {rem_q[31:0], rad_q[63:62]};
  assign trial  = {root_q, 2'b01};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sq_cnt_q <= 6'(SqrtSteps);
    end else if (cmd_i.start) begin
      sq_cnt_q <= '0;
    end else if (cmd_i.run && !sq_cnt_q[5]) begin
      sq_cnt_q <= sq_cnt_q + 6'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      ovf_q  <= sq_sum[64];
      rad_q  <= sq_sum[63:0];
      rem_q  <= '0;
      root_q <= '0;
    end else if (cmd_i.run && !sq_cnt_q[5]) begin
      rad_q <= {rad_q[61:0], 2'b00};
      if (rem_n >= trial) begin
        rem_q  <= rem_n - trial;
        root_q <= {root_q[30:0], 1'b1};
      end else begin
        rem_q  <= rem_n;
        root_q <= {root_q[30:0], 1'b0};
      end
    end
  end

  // cordic bearing: normalize, then vectoring iterations
  logic signed [43:0] cx_q, cy_q, cx_sh, cy_sh, dx_ext, dy_ext;
  logic signed [19:0] cz_q, cz_rnd;
  logic [4:0]         c_cnt_q;
  logic               c_norm_q, zero_q, c_done;
  logic signed [15:0] bear;

  assign dx_ext = 44'(dx_q);
  assign dy_ext = 44'(dy_q);
  assign cx_sh  = cx_q >>> c_cnt_q;
  assign cy_sh  = cy_q >>> c_cnt_q;
  assign c_done = zero_q || (c_cnt_q == CordicEnd);
  assign cz_rnd = cz_q + 20'sd8;
  assign bear   = zero_q ? 16'sd0 : cz_rnd[19:4];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_cnt_q  <= CordicEnd;
      c_norm_q <= 1'b0;
      zero_q   <= 1'b0;
    end else if (cmd_i.start) begin
      c_cnt_q  <= '0;
      c_norm_q <= 1'b1;
      zero_q   <= (dx_q == '0) && (dy_q == '0);
    end else if (cmd_i.run && !c_done) begin
      if (c_norm_q) begin
        if (!(cx_q < NormLimit && cy_q < NormLimit && cy_q > -NormLimit)) begin
          c_norm_q <= 1'b0;
        end
      end else begin
        c_cnt_q <= c_cnt_q + 5'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      if (dx_q[32]) begin
        cx_q <= -dx_ext;
        cy_q <= -dy_ext;
        cz_q <= dy_q[32] ? -20'(CordicPi) : 20'(CordicPi);
      end else begin
        cx_q <= dx_ext;
        cy_q <= dy_ext;
        cz_q <= '0;
      end
    end else if (cmd_i.run && !c_done) begin
      if (c_norm_q) begin
        if (cx_q < NormLimit && cy_q < NormLimit && cy_q > -NormLimit) begin
          cx_q <= cx_q <<< 1;
          cy_q <= cy_q <<< 1;
        end
      end else if (cy_q > 44'sd0) begin
        cx_q <= cx_q + cy_sh;
        cy_q <= cy_q - cx_sh;
        cz_q <= cz_q + atan_entry(c_cnt_q);
      end else begin
        cx_q <= cx_q - cy_sh;
        cy_q <= cy_q + cx_sh;
        cz_q <= cz_q - atan_entry(c_cnt_q);
      end
    end
  end

  assign status_o.run_done = sq_cnt_q[5] && c_done;

  // angle errors
  logic signed [17:0] alpha_raw, alpha_q;
  logic signed [18:0] beta_raw, beta_q;

  assign alpha_raw = 18'(bear) - 18'(heading_q);
  assign beta_raw  = 19'(goal_head_q) - 19'(heading_q) - 19'(alpha_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.alpha) begin
      if (alpha_raw < -18'(AngPi)) alpha_q <= alpha_raw + 18'(AngTwoPi);
      else if (alpha_raw > 18'(AngPi)) alpha_q <= alpha_raw - 18'(AngTwoPi);
      else alpha_q <= alpha_raw;
    end
    if (cmd_i.beta) begin
      if (beta_raw < -19'(AngPi)) beta_q <= beta_raw + 19'(AngTwoPi);
      else if (beta_raw > 19'(AngPi)) beta_q <= beta_raw - 19'(AngTwoPi);
      else beta_q <= beta_raw;
    end
  end

  // gains
  logic        [31:0] rho, rho_q;
  logic signed [48:0] spd_q;
  logic signed [33:0] ta_q;
  logic signed [34:0] tb_q;
  logic signed [49:0] spd_rnd;
  logic signed [35:0] turn_sum;

  assign rho      = ovf_q ? 32'hFFFF_FFFF : root_q;
  assign spd_rnd  = 50'(spd_q) + 50'sd128;
  assign turn_sum = 36'(ta_q) + 36'(tb_q) + 36'sd8;

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_a) begin
      rho_q <= rho;
      spd_q <= gain_dist_q * $signed({1'b0, rho});
      ta_q  <= gain_bear_q * alpha_q;
    end
    if (cmd_i.mul_b) tb_q <= gain_final_q * beta_q;
  end

  // result register
  logic out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.fin) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.fin) begin
      if (spd_rnd[49:39] != {11{spd_rnd[49]}}) begin
        speed_o <= spd_rnd[49] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
      end else begin
        speed_o <= spd_rnd[39:8];
      end
      turn_rate_o         <= turn_sum[35:4];
      distance_o          <= rho_q;
      bearing_error_o     <= alpha_q[15:0];
      final_angle_error_o <= beta_q[16:0];
      arrived_o           <= rho_q <= stop_dist_q;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign status_o.out_busy = out_valid_q;

endmodule

FILE: rtl/move_to_pose_controller.sv
`timescale 1ns / 1ps
// processing: the 32-step square root sets the shortest time from request accept to result valid;
// the cordic normalize and iterations set the longest, for short vectors
// requests: one at a time; the next is accepted once the last result is written to the output
// register, later while the previous result still waits in the output register
// reset: asynchronous active low; pose cleared, gains and goal to defaults,
// no clearing pass
module move_to_pose_controller
  import mtp_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  mtp_in_if.sink    in_i,
  mtp_out_if.source out_o,
  mtp_cfg_if.sink   cfg_i
);

  mtp_cmd_t    cmd;
  mtp_status_t status;
  logic        in_ready;

  assign in_i.ready  = in_ready;
  assign cfg_i.ready = 1'b1;

  mtp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  mtp_datapath u_datapath (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cmd_i               (cmd),
    .status_o            (status),
    .load_start_i        (in_i.load_start),
    .pos_x_i             (in_i.pos_x),
    .pos_y_i             (in_i.pos_y),
    .heading_in_i        (in_i.heading_in),
    .cfg_valid_i         (cfg_i.valid),
    .cfg_index_i         (cfg_i.index),
    .cfg_data_i          (cfg_i.data),
    .out_valid_o         (out_o.valid),
    .out_ready_i         (out_o.ready),
    .speed_o             (out_o.speed),
    .turn_rate_o         (out_o.turn_rate),
    .distance_o          (out_o.distance),
    .bearing_error_o     (out_o.bearing_error),
    .final_angle_error_o (out_o.final_angle_error),
    .arrived_o           (out_o.arrived)
  );

endmodule
